FILE: rtl/tbwm_pkg.sv
// tbwm_pkg: shared types, constants and the level table for the two-bit
// waveform modulator. Used by tbwm_ctrl, tbwm_dp and the top level.
package tbwm_pkg;

  // field and register widths
  localparam int unsigned SYNC_W = 16;
  localparam int unsigned LEN_W  = 6;
  localparam int unsigned CNT_W  = 17;
  localparam int unsigned WORD_W = 64;

  // configuration register indexes
  localparam logic [1:0] REG_SYNC_INTERVAL   = 2'd0;
  localparam logic [1:0] REG_SILENCE_LENGTH  = 2'd1;
  localparam logic [1:0] REG_PREAMBLE_LENGTH = 2'd2;

  // input function codes
  localparam logic FUNC_BYTE = 1'b0;
  localparam logic FUNC_SYNC = 1'b1;

  // reset values and run limits
  localparam logic [SYNC_W-1:0] SYNC_INTERVAL_RST   = 16'd1000;
  localparam logic [LEN_W-1:0]  SILENCE_LENGTH_RST  = 6'd50;
  localparam logic [LEN_W-1:0]  PREAMBLE_LENGTH_RST = 6'd50;
  localparam logic [LEN_W-1:0]  MAX_SILENCE         = 6'd56;
  localparam logic [LEN_W-1:0]  MAX_PREAMBLE        = 6'd50;
  localparam logic [LEN_W-1:0]  SAMPLES_PER_CHUNK   = 6'd8;
  localparam logic [3:0]        FULL_COUNT          = 4'd8;
  localparam logic [7:0]        SILENCE_LEVEL       = 8'h80;

  // table start points of the fixed sync run chunks
  localparam logic [2:0] PREAMBLE_START = 3'd0;
  localparam logic [2:0] MARK_START     = 3'd2;

  // one period of the level pattern (eight entries, indexes wrap modulo eight)
  localparam logic [7:0] LEVEL_TAB [8] = '{
    8'h40, 8'h40, 8'hC0, 8'hC0, 8'hC0, 8'hC0, 8'h40, 8'h40
  };

  typedef enum logic [1:0] {
    KIND_DATA     = 2'd0,
    KIND_SILENCE  = 2'd1,
    KIND_PREAMBLE = 2'd2,
    KIND_MARK     = 2'd3
  } kind_t;

  // what the datapath loads into the output register this cycle
  typedef enum logic [2:0] {
    EMIT_NONE,
    EMIT_FIRST,
    EMIT_DATA,
    EMIT_SILENCE,
    EMIT_PREAMBLE,
    EMIT_MARK
  } emit_t;

  typedef struct packed {
    emit_t emit;
    logic  last;
    logic  sync_load;
    logic  cnt_inc;
  } dp_cmd_t;

  typedef struct packed {
    logic slot_free;
    logic sil_zero;
    logic sil_last;
    logic pre_zero;
    logic pre_last;
    logic cnt_over;
  } dp_stat_t;

  // eight samples read from the level table starting at start
  function automatic logic [WORD_W-1:0] chunk_word(input logic [2:0] start);
    logic [WORD_W-1:0] w;
    w = '0;
    for (int k = 0; k < 8; k++) begin
      w[8*k +: 8] = LEVEL_TAB[3'(start + 3'(k))];
    end
    return w;
  endfunction

endpackage

FILE: rtl/tbwm_ctrl.sv
// tbwm_ctrl: sequencer for data symbols and sync runs of the modulator.
// Depends on tbwm_pkg; drives commands into tbwm_dp and reads its status.
module tbwm_ctrl
  import tbwm_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  input  logic     in_func,
  input  dp_stat_t stat,
  output logic     in_stall,
  output dp_cmd_t  cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DATA,
    S_SIL,
    S_PRE,
    S_MARK
  } state_t;

  state_t     state_r, state_nxt;
  logic [1:0] dcnt_r, dcnt_nxt;

  // next state and commands
  always_comb begin
    state_nxt     = state_r;
    dcnt_nxt      = dcnt_r;
    in_stall      = 1'b1;
    cmd.emit      = EMIT_NONE;
    cmd.last      = 1'b0;
    cmd.sync_load = 1'b0;
    cmd.cnt_inc   = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_stall = !stat.slot_free;
        if (in_valid && stat.slot_free) begin
          if (in_func) begin
            cmd.sync_load = 1'b1;
            state_nxt     = S_SIL;
          end else begin
            cmd.emit  = EMIT_FIRST;
            dcnt_nxt  = 2'd1;
            state_nxt = S_DATA;
          end
        end
      end
      S_DATA: begin
        if (stat.slot_free) begin
          cmd.emit = EMIT_DATA;
          if (dcnt_r == 2'd3) begin
            cmd.cnt_inc = 1'b1;
            if (stat.cnt_over) begin
              cmd.sync_load = 1'b1;
              state_nxt     = S_SIL;
            end else begin
              cmd.last  = 1'b1;
              state_nxt = S_IDLE;
            end
          end else begin
            dcnt_nxt = dcnt_r + 2'd1;
          end
        end
      end
      S_SIL: begin
        if (stat.sil_zero) begin
          state_nxt = S_PRE;
        end else if (stat.slot_free) begin
          cmd.emit = EMIT_SILENCE;
          if (stat.sil_last) begin
            state_nxt = S_PRE;
          end
        end
      end
      S_PRE: begin
        if (stat.pre_zero) begin
          state_nxt = S_MARK;
        end else if (stat.slot_free) begin
          cmd.emit = EMIT_PREAMBLE;
          if (stat.pre_last) begin
            state_nxt = S_MARK;
          end
        end
      end
      S_MARK: begin
        if (stat.slot_free) begin
          cmd.emit  = EMIT_MARK;
          cmd.last  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // state and symbol counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      dcnt_r  <= 2'd0;
    end else begin
      state_r <= state_nxt;
      dcnt_r  <= dcnt_nxt;
    end
  end

endmodule

FILE: rtl/tbwm_dp.sv
// tbwm_dp: configuration registers, phase and byte counters, run counters
// and the output register of the modulator. Depends on tbwm_pkg.
module tbwm_dp
  import tbwm_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [SYNC_W-1:0]  cfg_data,
  input  logic [7:0]         in_data_byte,
  input  logic               out_stall,
  input  dp_cmd_t            cmd,
  output dp_stat_t           stat,
  output logic               out_valid,
  output logic [WORD_W-1:0]  out_sample_word,
  output logic [3:0]         out_sample_count,
  output logic [1:0]         out_chunk_kind,
  output logic               out_last_of_run
);

  logic [SYNC_W-1:0] sync_interval_r;
  logic [LEN_W-1:0]  silence_length_r;
  logic [LEN_W-1:0]  preamble_length_r;
  logic              phase_r;
  logic [CNT_W-1:0]  bytes_r;
  logic [5:0]        byte_r;
  logic [LEN_W-1:0]  sil_rem_r;
  logic [LEN_W-1:0]  pre_rem_r;
  logic              valid_r;
  logic [WORD_W-1:0] word_r;
  logic [3:0]        count_r;
  kind_t             kind_r;
  logic              last_r;

  logic [CNT_W-1:0]  bytes_inc;
  logic [3:0]        sil_cnt;
  logic [WORD_W-1:0] word_nxt;
  logic [3:0]        count_nxt;
  kind_t             kind_nxt;

  // silence samples in the low bytes, zero above
  function automatic logic [WORD_W-1:0] silence_word(input logic [3:0] cnt);
    logic [WORD_W-1:0] w;
    w = '0;
    for (int k = 0; k < 8; k++) begin
      if (4'(k) < cnt) begin
        w[8*k +: 8] = SILENCE_LEVEL;
      end
    end
    return w;
  endfunction

  // status toward the controller
  assign bytes_inc      = bytes_r + 17'd1;
  assign sil_cnt        = (sil_rem_r > SAMPLES_PER_CHUNK) ? FULL_COUNT : sil_rem_r[3:0];
  assign stat.slot_free = !valid_r || !out_stall;
  assign stat.sil_zero  = (sil_rem_r == '0);
  assign stat.sil_last  = (sil_rem_r <= SAMPLES_PER_CHUNK);
  assign stat.pre_zero  = (pre_rem_r == '0);
  assign stat.pre_last  = (pre_rem_r == 6'd1);
  assign stat.cnt_over  = (bytes_inc > {1'b0, sync_interval_r});

  // chunk selection
  always_comb begin
    word_nxt  = '0;
    count_nxt = FULL_COUNT;
    kind_nxt  = KIND_DATA;
    unique case (cmd.emit)
      EMIT_NONE: begin
        word_nxt = '0;
      end
      EMIT_FIRST: begin
        word_nxt = chunk_word({in_data_byte[1:0], phase_r});
      end
      EMIT_DATA: begin
        word_nxt = chunk_word({byte_r[1:0], phase_r});
      end
      EMIT_SILENCE: begin
        word_nxt  = silence_word(sil_cnt);
        count_nxt = sil_cnt;
        kind_nxt  = KIND_SILENCE;
      end
      EMIT_PREAMBLE: begin
        word_nxt = chunk_word(PREAMBLE_START);
        kind_nxt = KIND_PREAMBLE;
      end
      EMIT_MARK: begin
        word_nxt = chunk_word(MARK_START);
        kind_nxt = KIND_MARK;
      end
      default: begin
        word_nxt = '0;
      end
    endcase
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sync_interval_r   <= SYNC_INTERVAL_RST;
      silence_length_r  <= SILENCE_LENGTH_RST;
      preamble_length_r <= PREAMBLE_LENGTH_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SYNC_INTERVAL:   sync_interval_r   <= cfg_data;
        REG_SILENCE_LENGTH:  silence_length_r  <= cfg_data[LEN_W-1:0];
        REG_PREAMBLE_LENGTH: preamble_length_r <= cfg_data[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // phase, byte counter and sync run counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= 1'b0;
      bytes_r   <= '0;
      sil_rem_r <= '0;
      pre_rem_r <= '0;
    end else begin
      if (cmd.emit == EMIT_FIRST || cmd.emit == EMIT_DATA) begin
        phase_r <= !phase_r;
      end else if (cmd.emit == EMIT_MARK) begin
        phase_r <= 1'b0;
      end
      if (cmd.sync_load) begin
        bytes_r <= '0;
      end else if (cmd.cnt_inc) begin
        bytes_r <= bytes_inc;
      end
      if (cmd.sync_load) begin
        sil_rem_r <= (silence_length_r > MAX_SILENCE) ? MAX_SILENCE : silence_length_r;
        pre_rem_r <= (preamble_length_r > MAX_PREAMBLE) ? MAX_PREAMBLE : preamble_length_r;
      end else begin
        if (cmd.emit == EMIT_SILENCE) begin
          sil_rem_r <= sil_rem_r - {2'b00, sil_cnt};
        end
        if (cmd.emit == EMIT_PREAMBLE) begin
          pre_rem_r <= pre_rem_r - 6'd1;
        end
      end
    end
  end

  // remaining symbols of the current byte
  always_ff @(posedge clk) begin
    if (cmd.emit == EMIT_FIRST) begin
      byte_r <= in_data_byte[7:2];
    end else if (cmd.emit == EMIT_DATA) begin
      byte_r <= {2'b00, byte_r[5:2]};
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (cmd.emit != EMIT_NONE) begin
      valid_r <= 1'b1;
    end else if (!out_stall) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit != EMIT_NONE) begin
      word_r  <= word_nxt;
      count_r <= count_nxt;
      kind_r  <= kind_nxt;
      last_r  <= cmd.last;
    end
  end

  assign out_valid        = valid_r;
  assign out_sample_word  = word_r;
  assign out_sample_count = count_r;
  assign out_chunk_kind   = kind_r;
  assign out_last_of_run  = last_r;

endmodule

FILE: rtl/two_bit_waveform_modulator.sv
// two_bit_waveform_modulator: top level, joins controller and datapath.
// Depends on tbwm_pkg, tbwm_ctrl and tbwm_dp.
//
// Usage:
// - input channel (in_valid/in_stall): func 0 sends data_byte as four
//   eight-sample chunks, lowest bit pair first; func 1 forces a sync run
// - output channel (out_valid/out_stall): one chunk per transfer, first
//   sample in the lowest byte; last_of_run marks the final chunk of an item
// - config channel (cfg_valid/cfg_ready/cfg_index/cfg_data): always ready;
//   index 0 sync interval, 1 silence length, 2 preamble length
// - the first chunk of a data byte is in the output register in the cycle
//   after the input transfer
// - a data byte goes out one chunk per cycle while out_stall is low, set by
//   the single output register; a sync run does the same, but the start of
//   a forced run and each empty silence or preamble part load no chunk
// - input is taken only in the idle state and only while the output register
//   is empty or being drained in the same cycle
// - a stalled receiver holds the output register and stops further chunks
// - reset: config returns to 1000/50/50, phase and byte counter clear,
//   output register empties
module two_bit_waveform_modulator
  import tbwm_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_func,
  input  logic [7:0]         in_data_byte,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [WORD_W-1:0]  out_sample_word,
  output logic [3:0]         out_sample_count,
  output logic [1:0]         out_chunk_kind,
  output logic               out_last_of_run,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [SYNC_W-1:0]  cfg_data
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  assign cfg_ready = 1'b1;

  // sequencer
  tbwm_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_func  (in_func),
    .stat     (stat),
    .in_stall (in_stall),
    .cmd      (cmd)
  );

  // datapath and output register
  tbwm_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_valid && cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_data_byte     (in_data_byte),
    .out_stall        (out_stall),
    .cmd              (cmd),
    .stat             (stat),
    .out_valid        (out_valid),
    .out_sample_word  (out_sample_word),
    .out_sample_count (out_sample_count),
    .out_chunk_kind   (out_chunk_kind),
    .out_last_of_run  (out_last_of_run)
  );

  // a data byte transfer puts its first symbol chunk in the output register
  a_first_chunk: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && !in_func |=> out_valid && out_chunk_kind == KIND_DATA)
    else $error("data byte did not produce a symbol chunk");

  // a forced sync transfer is followed by an empty output register
  a_sync_gap: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_func |=> !out_valid)
    else $error("output register busy after forced sync transfer");

  // only silence chunks are partly filled
  a_partial: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_sample_count != FULL_COUNT |->
      out_chunk_kind == KIND_SILENCE && out_sample_count != 4'd0)
    else $error("partial chunk outside silence");

  // a run ends on a data chunk or on the sync mark
  a_last_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last_of_run |->
      out_chunk_kind == KIND_DATA || out_chunk_kind == KIND_MARK)
    else $error("run ended on silence or preamble");

endmodule
